@@ hw/rtl/ehp_pkg.sv @@
// ----------------------------------------------------------------------------
// ehp_pkg
// Shared types and codes of the expiry min-heap timer queue.
// ----------------------------------------------------------------------------
package ehp_pkg;

  // Port field widths, fixed by the stream word layout.
  localparam int ID_W   = 8;
  localparam int TIME_W = 32;
  localparam int HELD_W = 7;

  // At most this many expired entries are removed by one tick.
  localparam int MAX_OUT = 64;
  localparam int OUT_CW  = $clog2(MAX_OUT + 1);

  // Operation carried on the input side.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Result kinds.
  localparam logic [1:0] RK_INSERT  = 2'd0;
  localparam logic [1:0] RK_EXPIRED = 2'd1;
  localparam logic [1:0] RK_NONE    = 2'd2;

  typedef logic [ID_W-1:0]   port_id_t;
  typedef logic [TIME_W-1:0] port_time_t;
  typedef logic [HELD_W-1:0] held_t;

  typedef struct packed {
    logic [1:0] kind;
    port_id_t   id;
    logic       acc;
    held_t      held;
    logic       last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SU_READ,
    ST_SU_CMP,
    ST_INS_FIN,
    ST_TK_READ,
    ST_TK_CMP,
    ST_SD_READ,
    ST_SD_CMP,
    ST_TK_FIN
  } state_t;

endpackage

@@ hw/rtl/ehp_mem.sv @@
// ----------------------------------------------------------------------------
// ehp_mem
// Heap storage: one write port and two read ports with registered data.
// ----------------------------------------------------------------------------
module ehp_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/ehp_out.sv @@
// ----------------------------------------------------------------------------
// ehp_out
// Output register of the result stream and packing of the result word.
// ----------------------------------------------------------------------------
module ehp_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ehp_pkg::res_t res,
  output logic          free,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [15:0]   m_axis_tdata,  // expired_id[7:0], insert_accepted, entries_held[6:0]
  output logic [1:0]    m_axis_tuser,  // result_kind[1:0]
  output logic          m_axis_tlast
);

  ehp_pkg::res_t hold;

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hold <= res;
    end
  end

  assign m_axis_tdata = {hold.held, hold.acc, hold.id};
  assign m_axis_tuser = hold.kind;
  assign m_axis_tlast = hold.last;

endmodule

@@ hw/rtl/ehp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ehp_ctrl
// Sequencer of the heap: sift-up on insert, root removal and sift-down on tick.
// ----------------------------------------------------------------------------
module ehp_ctrl #(
  parameter int HEAP_DEPTH = 64,
  parameter int ID_WIDTH   = 8,
  parameter int TIME_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  ehp_pkg::port_id_t             in_id,
  input  ehp_pkg::port_time_t           in_time,
  output logic                          mem_we,
  output logic [$clog2(HEAP_DEPTH)-1:0] mem_waddr,
  output logic [TIME_WIDTH+ID_WIDTH-1:0] mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(HEAP_DEPTH)-1:0] mem_raddr_a,
  output logic [$clog2(HEAP_DEPTH)-1:0] mem_raddr_b,
  input  logic [TIME_WIDTH+ID_WIDTH-1:0] mem_rdata_a,
  input  logic [TIME_WIDTH+ID_WIDTH-1:0] mem_rdata_b,
  input  logic                          out_free,
  output logic                          out_push,
  output ehp_pkg::res_t                 out_res
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int XW = AW + 2;

  ehp_pkg::state_t state, state_next;

  logic [CW-1:0]                 count;
  logic [AW-1:0]                 pos;
  logic [TIME_WIDTH-1:0]         cur_time;
  logic [ID_WIDTH-1:0]           cur_id;
  logic [TIME_WIDTH-1:0]         tick_time;
  logic [ehp_pkg::OUT_CW-1:0]    n_out;
  logic                          pend_valid;
  logic [ID_WIDTH-1:0]           pend_id;
  logic [CW-1:0]                 pend_held;
  logic                          ins_ok;

  logic [TIME_WIDTH-1:0] a_time, b_time;
  logic [ID_WIDTH-1:0]   a_id, b_id;
  logic [AW-1:0]         par_addr;
  logic [XW-1:0]         l_idx, r_idx, count_x;
  logic                  l_valid, r_valid;
  logic                  take_r;
  logic [TIME_WIDTH-1:0] child_time;
  logic [ID_WIDTH-1:0]   child_id;
  logic [AW-1:0]         child_pos;
  logic [CW-1:0]         count_m1;
  logic                  is_full, more, expired;

  assign a_time = mem_rdata_a[TIME_WIDTH+ID_WIDTH-1:ID_WIDTH];
  assign a_id   = mem_rdata_a[ID_WIDTH-1:0];
  assign b_time = mem_rdata_b[TIME_WIDTH+ID_WIDTH-1:ID_WIDTH];
  assign b_id   = mem_rdata_b[ID_WIDTH-1:0];

  assign par_addr = (pos - AW'(1)) >> 1;
  assign l_idx    = {1'b0, pos, 1'b1};
  assign r_idx    = l_idx + XW'(1);
  assign count_x  = XW'(count);
  assign l_valid  = l_idx < count_x;
  assign r_valid  = r_idx < count_x;

  // The right child wins only when strictly smaller than the left.
  assign take_r     = r_valid && (b_time < a_time);
  assign child_time = take_r ? b_time : a_time;
  assign child_id   = take_r ? b_id : a_id;
  assign child_pos  = take_r ? r_idx[AW-1:0] : l_idx[AW-1:0];

  assign count_m1 = count - CW'(1);
  assign is_full  = count == CW'(HEAP_DEPTH);
  assign more     = (count != '0) && (n_out != ehp_pkg::OUT_CW'(ehp_pkg::MAX_OUT));
  assign expired  = a_time <= tick_time;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ehp_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == ehp_pkg::OP_TICK) begin
            state_next = ehp_pkg::ST_TK_READ;
          end else if (is_full) begin
            state_next = ehp_pkg::ST_INS_FIN;
          end else begin
            state_next = ehp_pkg::ST_SU_READ;
          end
        end
      end
      ehp_pkg::ST_SU_READ: begin
        state_next = (pos == '0) ? ehp_pkg::ST_INS_FIN : ehp_pkg::ST_SU_CMP;
      end
      ehp_pkg::ST_SU_CMP: begin
        state_next = (cur_time >= a_time) ? ehp_pkg::ST_INS_FIN : ehp_pkg::ST_SU_READ;
      end
      ehp_pkg::ST_INS_FIN: begin
        if (out_free) begin
          state_next = ehp_pkg::ST_IDLE;
        end
      end
      ehp_pkg::ST_TK_READ: begin
        state_next = more ? ehp_pkg::ST_TK_CMP : ehp_pkg::ST_TK_FIN;
      end
      ehp_pkg::ST_TK_CMP: begin
        if (!expired) begin
          state_next = ehp_pkg::ST_TK_FIN;
        end else if (!pend_valid || out_free) begin
          state_next = ehp_pkg::ST_SD_READ;
        end
      end
      ehp_pkg::ST_SD_READ: begin
        state_next = l_valid ? ehp_pkg::ST_SD_CMP : ehp_pkg::ST_TK_READ;
      end
      ehp_pkg::ST_SD_CMP: begin
        state_next = (cur_time <= child_time) ? ehp_pkg::ST_TK_READ : ehp_pkg::ST_SD_READ;
      end
      ehp_pkg::ST_TK_FIN: begin
        if (out_free) begin
          state_next = ehp_pkg::ST_IDLE;
        end
      end
      default: state_next = ehp_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses and result pushes.
  always_comb begin
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pos;
    mem_wdata   = {cur_time, cur_id};
    mem_re      = 1'b0;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    out_push    = 1'b0;
    out_res     = '0;
    case (state)
      ehp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ehp_pkg::ST_SU_READ: begin
        if (pos == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re      = 1'b1;
          mem_raddr_a = par_addr;
        end
      end
      ehp_pkg::ST_SU_CMP: begin
        mem_we = 1'b1;
        if (cur_time < a_time) begin
          mem_wdata = mem_rdata_a;
        end
      end
      ehp_pkg::ST_INS_FIN: begin
        out_push     = out_free;
        out_res.kind = ehp_pkg::RK_INSERT;
        out_res.acc  = ins_ok;
        out_res.held = ehp_pkg::held_t'(count);
        out_res.last = 1'b1;
      end
      ehp_pkg::ST_TK_READ: begin
        if (more) begin
          mem_re      = 1'b1;
          mem_raddr_b = count_m1[AW-1:0];
        end
      end
      ehp_pkg::ST_TK_CMP: begin
        // The word held back is sent once the next root proves expired too.
        out_push     = expired && pend_valid && out_free;
        out_res.kind = ehp_pkg::RK_EXPIRED;
        out_res.id   = ehp_pkg::port_id_t'(pend_id);
        out_res.held = ehp_pkg::held_t'(pend_held);
      end
      ehp_pkg::ST_SD_READ: begin
        if (l_valid) begin
          mem_re      = 1'b1;
          mem_raddr_a = l_idx[AW-1:0];
          mem_raddr_b = r_valid ? r_idx[AW-1:0] : l_idx[AW-1:0];
        end else begin
          mem_we = 1'b1;
        end
      end
      ehp_pkg::ST_SD_CMP: begin
        mem_we = 1'b1;
        if (cur_time > child_time) begin
          mem_wdata = {child_time, child_id};
        end
      end
      ehp_pkg::ST_TK_FIN: begin
        out_push     = out_free;
        out_res.last = 1'b1;
        if (pend_valid) begin
          out_res.kind = ehp_pkg::RK_EXPIRED;
          out_res.id   = ehp_pkg::port_id_t'(pend_id);
          out_res.held = ehp_pkg::held_t'(pend_held);
        end else begin
          out_res.kind = ehp_pkg::RK_NONE;
          out_res.held = ehp_pkg::held_t'(count);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ehp_pkg::ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ehp_pkg::ST_IDLE: begin
          if (in_valid && in_op == ehp_pkg::OP_TICK) begin
            pend_valid <= 1'b0;
          end else if (in_valid && !is_full) begin
            count <= count + CW'(1);
          end
        end
        ehp_pkg::ST_TK_CMP: begin
          if (expired && (!pend_valid || out_free)) begin
            pend_valid <= 1'b1;
            count      <= count_m1;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ehp_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == ehp_pkg::OP_TICK) begin
            tick_time <= TIME_WIDTH'(in_time);
            n_out     <= '0;
          end else begin
            ins_ok   <= !is_full;
            cur_time <= TIME_WIDTH'(in_time);
            cur_id   <= ID_WIDTH'(in_id);
            pos      <= count[AW-1:0];
          end
        end
      end
      ehp_pkg::ST_SU_CMP: begin
        if (cur_time < a_time) begin
          pos <= par_addr;
        end
      end
      ehp_pkg::ST_TK_CMP: begin
        if (expired && (!pend_valid || out_free)) begin
          pend_id   <= a_id;
          pend_held <= count_m1;
          n_out     <= n_out + ehp_pkg::OUT_CW'(1);
          // The last leaf becomes the hole's occupant, starting at the root.
          cur_time  <= b_time;
          cur_id    <= b_id;
          pos       <= '0;
        end
      end
      ehp_pkg::ST_SD_CMP: begin
        if (cur_time > child_time) begin
          pos <= child_pos;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

endmodule

@@ hw/rtl/expiry_min_heap.sv @@
// ----------------------------------------------------------------------------
// expiry_min_heap
// Timer queue of id/expiry pairs kept as a binary min-heap in block memory.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel. tuser selects the operation: low
// for insert (tdata carries the id and the expiry time), high for tick
// (tdata carries the current time; the id bits are ignored). Results leave
// on the m_axis channel, tuser giving the result kind.
// An insert gives one word: accepted, or rejected when the heap is full. A
// tick gives one word per expired entry in expiry order, the final one with
// tlast set, or a single "nothing expired" word; at most 64 entries leave per
// tick and the rest wait for the next tick.
// One word is taken at a time. An insert reads the parent and then compares
// and writes for every level that it climbs, writes its slot directly when it
// reaches the root, then answers; the next word is taken only after the answer
// is pushed. A rejected insert is answered without touching the memory. A
// tick reads the root and the last leaf for each expired entry, moves the leaf
// down level by level until it stops, and closes with a final word. Every level
// is a memory read followed by a compare and write, so the single heap memory
// and its one write port set the pace of every operation.
// Reset empties the heap at once; the memory itself is not cleared. A
// stalled receiver holds the output word and the sequencer waits for the
// output register before it sends the next word; the next input word may
// already be taken while the final word of the previous one waits.
module expiry_min_heap #(
  parameter int HEAP_DEPTH = 64,
  parameter int ID_WIDTH   = 8,
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // entry_id[7:0], time_value[31:0]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // expired_id[7:0], insert_accepted, entries_held[6:0]
  output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
  output logic        m_axis_tlast
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int MW = TIME_WIDTH + ID_WIDTH;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [MW-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;
  logic          out_free, out_push;
  ehp_pkg::res_t out_res;

  ehp_mem #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  ehp_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .ID_WIDTH   (ID_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (s_axis_tuser),
    .in_id       (s_axis_tdata[7:0]),
    .in_time     (s_axis_tdata[39:8]),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b),
    .out_free    (out_free),
    .out_push    (out_push),
    .out_res     (out_res)
  );

  ehp_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (out_push),
    .res           (out_res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the expiry min-heap timer queue.
// ----------------------------------------------------------------------------
// A short table of hand-picked inserts and ticks comes first. Where a result
// is obvious it is typed into the table; the others come from a heap kept in
// the bench. Random bursts follow: small mixed runs around a moving clock and
// runs that fill the heap, overflow it and drain it with the largest time.
// Both stream sides stall at random, except during one quiet burst. Every
// output word is compared field by field with the oldest word still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int HEAP_SLOTS   = 64;
  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int TAIL_CYCLES  = 60;

  typedef struct {
    logic                op;
    ehp_pkg::port_id_t   id;
    ehp_pkg::port_time_t tm;
    bit                  typed;
    ehp_pkg::res_t       want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // entry_id[7:0], time_value[31:0]
  logic        s_axis_tuser = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // expired_id[7:0], insert_accepted, entries_held[6:0]
  logic [1:0]  m_axis_tuser;        // result_kind[1:0]
  logic        m_axis_tlast;

  // Shadow heap that tracks what the block should hold.
  ehp_pkg::port_time_t slot_time [HEAP_SLOTS];
  ehp_pkg::port_id_t   slot_id   [HEAP_SLOTS];
  int                  heap_fill = 0;

  ehp_pkg::res_t fresh_words[$];
  ehp_pkg::res_t awaited_words[$];
  stim_row_t     script[$];

  int                  errors = 0;
  int                  words_sent = 0;
  int                  cycle_count = 0;
  bit                  quiet = 1'b0;
  ehp_pkg::port_time_t now_time = 32'd1000;
  ehp_pkg::res_t       seen_word;
  ehp_pkg::res_t       due_word;

  expiry_min_heap dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 31);
  end

  function automatic ehp_pkg::res_t pack_result(logic [1:0] kind, ehp_pkg::port_id_t id,
                                                logic acc, logic last);
    ehp_pkg::res_t r;
    r.kind = kind;
    r.id   = id;
    r.acc  = acc;
    r.held = ehp_pkg::held_t'(heap_fill);
    r.last = last;
    return r;
  endfunction

  function automatic void swap_slots(int a, int b);
    ehp_pkg::port_time_t t;
    ehp_pkg::port_id_t   d;
    t = slot_time[a];
    d = slot_id[a];
    slot_time[a] = slot_time[b];
    slot_id[a]   = slot_id[b];
    slot_time[b] = t;
    slot_id[b]   = d;
  endfunction

  // Applies one word to the shadow heap and leaves its results in fresh_words.
  function automatic void heap_apply(logic op, ehp_pkg::port_id_t id,
                                     ehp_pkg::port_time_t tm);
    int                p;
    int                up;
    int                l;
    int                m;
    int                n;
    ehp_pkg::port_id_t gone;
    fresh_words = {};
    if (op == ehp_pkg::OP_INSERT) begin
      if (heap_fill >= HEAP_SLOTS) begin
        fresh_words.push_back(pack_result(ehp_pkg::RK_INSERT, '0, 1'b0, 1'b1));
        return;
      end
      slot_time[heap_fill] = tm;
      slot_id[heap_fill]   = id;
      heap_fill++;
      p = heap_fill - 1;
      // An equal parent stops the climb.
      while (p > 0) begin
        up = (p - 1) / 2;
        if (slot_time[p] >= slot_time[up]) break;
        swap_slots(p, up);
        p = up;
      end
      fresh_words.push_back(pack_result(ehp_pkg::RK_INSERT, '0, 1'b1, 1'b1));
      return;
    end
    n = 0;
    while (n < ehp_pkg::MAX_OUT && heap_fill > 0 && slot_time[0] <= tm) begin
      gone = slot_id[0];
      heap_fill--;
      slot_time[0] = slot_time[heap_fill];
      slot_id[0]   = slot_id[heap_fill];
      p = 0;
      // The right child wins only when strictly below the left one.
      while (1) begin
        l = 2 * p + 1;
        if (l >= heap_fill) break;
        m = l;
        if (l + 1 < heap_fill && slot_time[l + 1] < slot_time[l]) m = l + 1;
        if (slot_time[p] <= slot_time[m]) break;
        swap_slots(p, m);
        p = m;
      end
      fresh_words.push_back(pack_result(ehp_pkg::RK_EXPIRED, gone, 1'b0, 1'b0));
      n++;
    end
    if (n == 0) begin
      fresh_words.push_back(pack_result(ehp_pkg::RK_NONE, '0, 1'b0, 1'b1));
    end else begin
      fresh_words[fresh_words.size() - 1].last = 1'b1;
    end
  endfunction

  // Offers one word, waits for the handshake and books the words it causes.
  task automatic send_word(input logic op, input ehp_pkg::port_id_t id,
                           input ehp_pkg::port_time_t tm, input bit typed,
                           input ehp_pkg::res_t want);
    bit taken;
    if (!quiet && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 31);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {tm, id};
    do begin
      @(negedge clk);
      taken = s_axis_tvalid && s_axis_tready;
      @(posedge clk);
    end while (!taken);
    words_sent++;
    heap_apply(op, id, tm);
    if (typed) begin
      awaited_words.push_back(want);
    end else begin
      foreach (fresh_words[i]) awaited_words.push_back(fresh_words[i]);
    end
  endtask

  task automatic send_plain(input logic op, input ehp_pkg::port_id_t id,
                            input ehp_pkg::port_time_t tm);
    send_word(op, id, tm, 1'b0, '0);
  endtask

  task automatic add_row(input logic op, input ehp_pkg::port_id_t id,
                         input ehp_pkg::port_time_t tm, input bit typed,
                         input ehp_pkg::res_t want);
    stim_row_t r;
    r.op    = op;
    r.id    = id;
    r.tm    = tm;
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endtask

  function automatic ehp_pkg::res_t typed_word(logic [1:0] kind, ehp_pkg::port_id_t id,
                                               logic acc, int held);
    ehp_pkg::res_t r;
    r.kind = kind;
    r.id   = id;
    r.acc  = acc;
    r.held = ehp_pkg::held_t'(held);
    r.last = 1'b1;
    return r;
  endfunction

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  // Fills the heap, pushes a few inserts past full, then empties it in one tick.
  task automatic fill_heap();
    drain_outputs();
    while (heap_fill < HEAP_SLOTS) begin
      send_plain(ehp_pkg::OP_INSERT, ehp_pkg::port_id_t'($urandom_range(0, 255)),
                 ($urandom_range(0, 7) == 0) ? ehp_pkg::port_time_t'($urandom)
                                             : now_time + $urandom_range(0, 500));
    end
    repeat (3) begin
      send_plain(ehp_pkg::OP_INSERT, ehp_pkg::port_id_t'($urandom_range(0, 255)),
                 $urandom);
    end
    send_plain(ehp_pkg::OP_TICK, ehp_pkg::port_id_t'($urandom_range(0, 255)),
               32'hFFFF_FFFF);
  endtask

  task automatic mixed_burst(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 60) begin
        send_plain(ehp_pkg::OP_INSERT, ehp_pkg::port_id_t'($urandom_range(0, 255)),
                   ($urandom_range(0, 9) == 0) ? ehp_pkg::port_time_t'($urandom)
                                               : now_time + $urandom_range(0, 300));
      end else begin
        now_time = now_time + $urandom_range(0, 80);
        send_plain(ehp_pkg::OP_TICK, ehp_pkg::port_id_t'($urandom_range(0, 255)),
                   ($urandom_range(0, 11) == 0) ? ehp_pkg::port_time_t'($urandom)
                                                : now_time);
      end
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] want,
                                        logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_word.kind = m_axis_tuser;
      seen_word.id   = m_axis_tdata[7:0];
      seen_word.acc  = m_axis_tdata[8];
      seen_word.held = m_axis_tdata[15:9];
      seen_word.last = m_axis_tlast;
      if (awaited_words.size() == 0) begin
        errors++;
        $display("%0t ns: word with nothing due, expected none, got kind %0h id %0h",
                 $time, seen_word.kind, seen_word.id);
      end else begin
        due_word = awaited_words.pop_front();
        compare_field("result_kind", 32'(due_word.kind), 32'(seen_word.kind));
        compare_field("expired_id", 32'(due_word.id), 32'(seen_word.id));
        compare_field("insert_accepted", 32'(due_word.acc), 32'(seen_word.acc));
        compare_field("entries_held", 32'(due_word.held), 32'(seen_word.held));
        compare_field("last", 32'(due_word.last), 32'(seen_word.last));
      end
    end
  end

  initial begin
    int episode;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty heap, extremes of id and time, equal expiries, ids on ticks.
    add_row(ehp_pkg::OP_TICK,   8'h00, 32'h0000_0000, 1'b1,
            typed_word(ehp_pkg::RK_NONE, 8'h00, 1'b0, 0));
    add_row(ehp_pkg::OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b1,
            typed_word(ehp_pkg::RK_INSERT, 8'h00, 1'b1, 1));
    add_row(ehp_pkg::OP_INSERT, 8'h00, 32'h0000_0000, 1'b1,
            typed_word(ehp_pkg::RK_INSERT, 8'h00, 1'b1, 2));
    add_row(ehp_pkg::OP_INSERT, 8'hA5, 32'd100,       1'b0, '0);
    add_row(ehp_pkg::OP_INSERT, 8'h5A, 32'd100,       1'b0, '0);
    add_row(ehp_pkg::OP_INSERT, 8'h33, 32'd50,        1'b0, '0);
    add_row(ehp_pkg::OP_TICK,   8'hFF, 32'd0,         1'b0, '0);
    add_row(ehp_pkg::OP_TICK,   8'h00, 32'd49,        1'b0, '0);
    add_row(ehp_pkg::OP_TICK,   8'h00, 32'd100,       1'b0, '0);
    add_row(ehp_pkg::OP_TICK,   8'h00, 32'hFFFF_FFFE, 1'b0, '0);
    add_row(ehp_pkg::OP_TICK,   8'h00, 32'hFFFF_FFFF, 1'b1,
            typed_word(ehp_pkg::RK_EXPIRED, 8'hFF, 1'b0, 0));
    add_row(ehp_pkg::OP_TICK,   8'hFF, 32'hFFFF_FFFF, 1'b1,
            typed_word(ehp_pkg::RK_NONE, 8'h00, 1'b0, 0));
    add_row(ehp_pkg::OP_INSERT, 8'h01, 32'h8000_0000, 1'b0, '0);
    add_row(ehp_pkg::OP_INSERT, 8'h02, 32'h7FFF_FFFF, 1'b0, '0);
    add_row(ehp_pkg::OP_INSERT, 8'h03, 32'h8000_0000, 1'b0, '0);
    add_row(ehp_pkg::OP_INSERT, 8'h04, 32'h0000_0001, 1'b0, '0);
    add_row(ehp_pkg::OP_INSERT, 8'h80, 32'h7FFF_FFFF, 1'b0, '0);
    add_row(ehp_pkg::OP_TICK,   8'h00, 32'h7FFF_FFFF, 1'b0, '0);
    add_row(ehp_pkg::OP_INSERT, 8'h7F, 32'h8000_0000, 1'b0, '0);
    add_row(ehp_pkg::OP_TICK,   8'h00, 32'h8000_0000, 1'b0, '0);
    add_row(ehp_pkg::OP_TICK,   8'h00, 32'h0000_0000, 1'b1,
            typed_word(ehp_pkg::RK_NONE, 8'h00, 1'b0, 0));

    foreach (script[i]) begin
      send_word(script[i].op, script[i].id, script[i].tm, script[i].typed, script[i].want);
    end

    episode = 0;
    while (words_sent < script.size() + RANDOM_ITEMS) begin
      quiet <= (episode == 2);
      if (episode == 3 || episode == 7) begin
        fill_heap();
      end else begin
        mixed_burst((episode == 2) ? 40 : $urandom_range(12, 28));
      end
      episode++;
    end
    quiet <= 1'b0;

    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && awaited_words.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ehp_pkg.sv
hw/rtl/ehp_mem.sv
hw/rtl/ehp_out.sv
hw/rtl/ehp_ctrl.sv
hw/rtl/expiry_min_heap.sv
test/tb_top.sv
